// ===== rtl/omw_pkg.sv =====
// ----------------------------------------------------------------------------
// omw_pkg: shared types, constants and sine table
// Widths, register indexes and the quarter-wave sine lookup for the mixer.
// ----------------------------------------------------------------------------
package omw_pkg;

  localparam int WHEEL_COUNT = 4;
  localparam int DUTY_W      = 7;
  localparam int MUL_W       = 18;
  localparam int NUM_W       = 29;
  localparam int DEN_W       = 14;
  localparam int QUO_W       = 16;

  localparam logic [2:0] CFG_POWER_LIMIT      = 3'd0;
  localparam logic [2:0] CFG_PROP_GAIN        = 3'd1;
  localparam logic [2:0] CFG_DERIV_GAIN       = 3'd2;
  localparam logic [2:0] CFG_CORRECTION_LIMIT = 3'd3;
  localparam logic [2:0] CFG_SMOOTHING        = 3'd4;
  localparam logic [2:0] CFG_BRAKE_THRESHOLD  = 3'd5;

  localparam logic [12:0] SINE_TAB [0:90] = '{
    13'd0, 13'd71, 13'd143, 13'd214, 13'd286, 13'd357, 13'd428, 13'd499, 13'd570, 13'd641,
    13'd711, 13'd782, 13'd852, 13'd921, 13'd991, 13'd1060, 13'd1129, 13'd1198, 13'd1266,
    13'd1334, 13'd1401, 13'd1468, 13'd1534, 13'd1600, 13'd1666, 13'd1731, 13'd1796,
    13'd1860, 13'd1923, 13'd1986, 13'd2048, 13'd2110, 13'd2171, 13'd2231, 13'd2290,
    13'd2349, 13'd2408, 13'd2465, 13'd2522, 13'd2578, 13'd2633, 13'd2687, 13'd2741,
    13'd2793, 13'd2845, 13'd2896, 13'd2946, 13'd2996, 13'd3044, 13'd3091, 13'd3138,
    13'd3183, 13'd3228, 13'd3271, 13'd3314, 13'd3355, 13'd3396, 13'd3435, 13'd3474,
    13'd3511, 13'd3547, 13'd3582, 13'd3617, 13'd3650, 13'd3681, 13'd3712, 13'd3742,
    13'd3770, 13'd3798, 13'd3824, 13'd3849, 13'd3873, 13'd3896, 13'd3917, 13'd3937,
    13'd3956, 13'd3974, 13'd3991, 13'd4006, 13'd4021, 13'd4034, 13'd4046, 13'd4056,
    13'd4065, 13'd4074, 13'd4080, 13'd4086, 13'd4090, 13'd4094, 13'd4095, 13'd4096
  };

  // sine of a in 0..359 degrees, scale 4096
  function automatic logic signed [13:0] sine_of(input logic [8:0] a);
    logic [8:0]         i;
    logic               neg;
    logic signed [13:0] m;
    if (a <= 9'd90) begin
      i = a;
      neg = 1'b0;
    end else if (a <= 9'd180) begin
      i = 9'd180 - a;
      neg = 1'b0;
    end else if (a <= 9'd270) begin
      i = a - 9'd180;
      neg = 1'b1;
    end else begin
      i = 9'd360 - a;
      neg = 1'b1;
    end
    m = {1'b0, SINE_TAB[i[6:0]]};
    return neg ? -m : m;
  endfunction

endpackage

// ===== rtl/omw_if.sv =====
// ----------------------------------------------------------------------------
// omw_if: stream channels of the mixer
// Input command channel and wheel duty result channel, valid/ready.
// ----------------------------------------------------------------------------
interface omw_in_if;
  logic              valid;
  logic              ready;
  logic [8:0]        direction;
  logic [6:0]        speed;
  logic signed [7:0] target_heading;
  logic signed [8:0] measured_heading;
  logic              sample_tick;
  modport source (output valid, direction, speed, target_heading, measured_heading,
                  sample_tick, input ready);
  modport sink (input valid, direction, speed, target_heading, measured_heading,
                sample_tick, output ready);
endinterface

interface omw_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] wheel1_forward;
  logic [6:0] wheel1_reverse;
  logic [6:0] wheel2_forward;
  logic [6:0] wheel2_reverse;
  logic [6:0] wheel3_forward;
  logic [6:0] wheel3_reverse;
  logic [6:0] wheel4_forward;
  logic [6:0] wheel4_reverse;
  modport source (output valid, wheel1_forward, wheel1_reverse, wheel2_forward,
                  wheel2_reverse, wheel3_forward, wheel3_reverse, wheel4_forward,
                  wheel4_reverse, input ready);
  modport sink (input valid, wheel1_forward, wheel1_reverse, wheel2_forward,
                wheel2_reverse, wheel3_forward, wheel3_reverse, wheel4_forward,
                wheel4_reverse, output ready);
endinterface

// ===== rtl/omw_mul.sv =====
// ----------------------------------------------------------------------------
// omw_mul: shared signed multiplier
// One 18x18 signed multiply per cycle, product registered.
// ----------------------------------------------------------------------------
module omw_mul (
  input  logic                                   clk,
  input  logic signed [omw_pkg::MUL_W-1:0]       a,
  input  logic signed [omw_pkg::MUL_W-1:0]       b,
  output logic signed [2*omw_pkg::MUL_W-1:0]     p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule

// ===== rtl/omw_div.sv =====
// ----------------------------------------------------------------------------
// omw_div: radix-2 restoring divider
// Quotient of QUO_W bits, one bit per cycle; caller guarantees it fits.
// ----------------------------------------------------------------------------
module omw_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [omw_pkg::NUM_W-1:0]     num,
  input  logic [omw_pkg::DEN_W-1:0]     den,
  output logic                          done_r,
  output logic [omw_pkg::QUO_W-1:0]     quo_r
);
  localparam int CNT_W = $clog2(omw_pkg::QUO_W + 1);

  logic [omw_pkg::DEN_W:0]   rem_r, rem_nxt;
  logic [omw_pkg::QUO_W-1:0] low_r;
  logic [omw_pkg::DEN_W-1:0] den_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic [omw_pkg::DEN_W+1:0] trial;

  always_comb begin
    trial   = {rem_r, low_r[omw_pkg::QUO_W-1]};
    rem_nxt = rem_r;
    if (trial >= {2'b00, den_r}) begin
      rem_nxt = (omw_pkg::DEN_W+1)'(trial - {2'b00, den_r});
    end else begin
      rem_nxt = trial[omw_pkg::DEN_W:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // pulse after the last quotient bit
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(omw_pkg::QUO_W);
        rem_r  <= (omw_pkg::DEN_W+1)'(num[omw_pkg::NUM_W-1:omw_pkg::QUO_W]);
        low_r  <= num[omw_pkg::QUO_W-1:0];
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        low_r <= {low_r[omw_pkg::QUO_W-2:0], 1'b0};
        quo_r <= {quo_r[omw_pkg::QUO_W-2:0], trial >= {2'b00, den_r}};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end
endmodule

// ===== rtl/omni_wheel_mixer_with_heading_pd_core.sv =====
// ----------------------------------------------------------------------------
// omni_wheel_mixer_with_heading_pd_core: four-wheel omni mixer, PD heading
// Direction/speed to four wheel powers, PD heading hold, smoothing, duties.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_ch   | in  | valid/ready          | direction, speed, headings, tick
//  out_ch  | out | valid/ready          | wheelN_forward/reverse, N=1..4
//  cfg_*   | in  | cfg_we, no backpress | cfg_addr selects, cfg_wdata 12b
//
//  Each beat runs, per wheel, an angle load and the angle reduction steps,
//  then the PD steps (error, proportional, derivative, clamp), then per wheel
//  a scale multiply, a divide launch, a wait on the 16-bit serial divide
//  (no divide at zero speed) and the smoothing and duty steps, all on the
//  one multiplier; then a push and a return to idle.
//  in_ch.ready is high only in idle. A finished result waits in the output
//  register; a new beat may enter meanwhile, and its result is held in the
//  work registers until the output register frees.
//  Reset (synchronous, rst_n low) restores register defaults and clears
//  heading history and smoothing state; no clearing pass.
// ----------------------------------------------------------------------------
module omni_wheel_mixer_with_heading_pd_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [11:0] cfg_wdata,
  omw_in_if.sink      in_ch,
  omw_out_if.source   out_ch
);
  localparam int WC = omw_pkg::WHEEL_COUNT;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ALOAD = 4'd1;
  localparam logic [3:0] S_ARED  = 4'd2;
  localparam logic [3:0] S_ERR   = 4'd3;
  localparam logic [3:0] S_PDM   = 4'd4;
  localparam logic [3:0] S_PDA   = 4'd5;
  localparam logic [3:0] S_PDC   = 4'd6;
  localparam logic [3:0] S_WMUL  = 4'd7;
  localparam logic [3:0] S_WDIV  = 4'd8;
  localparam logic [3:0] S_WWAIT = 4'd9;
  localparam logic [3:0] S_WSUM  = 4'd10;
  localparam logic [3:0] S_WSM1  = 4'd11;
  localparam logic [3:0] S_WSM2  = 4'd12;
  localparam logic [3:0] S_WFIN  = 4'd13;
  localparam logic [3:0] S_PUSH  = 4'd14;

  // config registers
  logic [6:0]  plim_r, clim_r, brake_r;
  logic [11:0] kp_r, kd_r;
  logic [7:0]  smooth_r;

  logic [3:0]         state_r;
  logic [8:0]         dir_r;
  logic [6:0]         spd_r;
  logic signed [7:0]  tgt_r;
  logic signed [8:0]  meas_r;
  logic               tick_r;
  logic [1:0]         wk_r;
  logic [10:0]        ang_r;
  logic signed [13:0] sn_r [WC];
  logic [12:0]        maxabs_r;
  logic signed [9:0]  last_err_r, err_chg_r, err_r;
  logic signed [23:0] pd_r;
  logic signed [25:0] acc_r;
  logic signed [17:0] p_r;
  logic signed [15:0] sm_r [WC];
  logic               zero_r;
  logic [6:0]         duty_r [2*WC];
  logic [6:0]         out_duty_r [2*WC];
  logic               out_valid_r;

  // shared units
  logic signed [omw_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*omw_pkg::MUL_W-1:0] prod;
  logic                               div_start, div_done;
  logic [omw_pkg::NUM_W-1:0]          div_num;
  logic [omw_pkg::QUO_W-1:0]          div_quo;

  omw_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod));

  omw_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
                 .den({maxabs_r, 1'b0}), .done_r(div_done), .quo_r(div_quo));

  // combinational helpers
  logic signed [13:0] sine_cur, sn_cur;
  logic [12:0]        mag_cur;
  logic signed [10:0] err_now, dlt;
  logic signed [9:0]  dsat;
  logic signed [25:0] pd_sum;
  logic signed [23:0] clim_s;
  logic [15:0]        q_sel;
  logic signed [17:0] pw, p_raw, plim_s, p_clamp;
  logic signed [26:0] sm_sum, sm_abs;
  logic signed [17:0] sm_rnd, sm_mag;
  logic [6:0]         duty;
  logic               brake_hit;

  assign sine_cur = omw_pkg::sine_of(ang_r[8:0]);
  assign sn_cur   = sn_r[wk_r];
  assign mag_cur  = sn_cur[13] ? 13'(-sn_cur) : sn_cur[12:0];
  assign err_now  = 11'(tgt_r) - 11'(meas_r);
  assign dlt      = err_now - 11'(last_err_r);
  assign dsat     = (dlt > 11'sd511) ? 10'sd511 :
                    (dlt < -11'sd512) ? -10'sd512 : dlt[9:0];
  assign pd_sum   = acc_r + prod[25:0];
  assign clim_s   = $signed({9'd0, clim_r, 8'd0});
  assign q_sel    = zero_r ? '0 : div_quo;
  assign pw       = sn_cur[13] ? -$signed({2'b00, q_sel}) : $signed({2'b00, q_sel});
  assign p_raw    = (wk_r < 2'd2) ? pw - 18'(pd_r) : pw + 18'(pd_r);
  assign plim_s   = $signed({3'd0, plim_r, 8'd0});
  assign p_clamp  = (p_raw > plim_s) ? plim_s : (p_raw < -plim_s) ? -plim_s : p_raw;
  assign sm_sum   = 27'(acc_r) + $signed(prod[26:0]);
  assign sm_abs   = sm_sum[26] ? -sm_sum : sm_sum;
  assign sm_rnd   = sm_sum[26] ? -18'((sm_abs + 27'sd128) >>> 8)
                               : 18'((sm_abs + 27'sd128) >>> 8);
  assign sm_mag   = sm_rnd[17] ? -sm_rnd : sm_rnd;
  assign brake_hit = sm_mag < $signed({3'd0, brake_r, 8'd0});
  assign duty     = 7'((sm_mag + 18'sd128) >>> 8);

  assign div_start = (state_r == S_WDIV) && (spd_r != '0) && (maxabs_r != '0);
  assign div_num   = {prod[19:0], 9'd0} + {16'd0, maxabs_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_PDM:  begin mul_a = 18'(err_r);     mul_b = $signed({6'd0, kp_r}); end
      S_PDA:  begin mul_a = 18'(err_chg_r); mul_b = $signed({6'd0, kd_r}); end
      S_WMUL: begin mul_a = $signed({5'd0, mag_cur}); mul_b = $signed({11'd0, spd_r}); end
      S_WSM1: begin mul_a = p_r; mul_b = $signed(18'd256 - {10'd0, smooth_r}); end
      S_WSM2: begin mul_a = 18'(sm_r[wk_r]); mul_b = $signed({10'd0, smooth_r}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.wheel1_forward = out_duty_r[0];
  assign out_ch.wheel1_reverse = out_duty_r[1];
  assign out_ch.wheel2_forward = out_duty_r[2];
  assign out_ch.wheel2_reverse = out_duty_r[3];
  assign out_ch.wheel3_forward = out_duty_r[4];
  assign out_ch.wheel3_reverse = out_duty_r[5];
  assign out_ch.wheel4_forward = out_duty_r[6];
  assign out_ch.wheel4_reverse = out_duty_r[7];

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plim_r   <= 7'd100;
      kp_r     <= 12'd256;
      kd_r     <= 12'd0;
      clim_r   <= 7'd40;
      smooth_r <= 8'd0;
      brake_r  <= 7'd5;
    end else if (cfg_we) begin
      case (cfg_addr)
        omw_pkg::CFG_POWER_LIMIT:      plim_r   <= cfg_wdata[6:0];
        omw_pkg::CFG_PROP_GAIN:        kp_r     <= cfg_wdata;
        omw_pkg::CFG_DERIV_GAIN:       kd_r     <= cfg_wdata;
        omw_pkg::CFG_CORRECTION_LIMIT: clim_r   <= cfg_wdata[6:0];
        omw_pkg::CFG_SMOOTHING:        smooth_r <= cfg_wdata[7:0];
        omw_pkg::CFG_BRAKE_THRESHOLD:  brake_r  <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_err_r  <= '0;
      err_chg_r   <= '0;
      wk_r        <= '0;
      for (int k = 0; k < WC; k++) sm_r[k] <= '0;
    end else begin
      // push state owns the valid flag when it is reloading
      if (out_valid_r && out_ch.ready && (state_r != S_PUSH)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            dir_r    <= in_ch.direction;
            spd_r    <= (in_ch.speed > plim_r) ? plim_r : in_ch.speed;
            tgt_r    <= in_ch.target_heading;
            meas_r   <= in_ch.measured_heading;
            tick_r   <= in_ch.sample_tick;
            wk_r     <= '0;
            maxabs_r <= '0;
            state_r  <= S_ALOAD;
          end
        end
        S_ALOAD: begin
          ang_r   <= {2'b00, dir_r} + 11'd675 - 11'(wk_r) * 11'd90;
          state_r <= S_ARED;
        end
        S_ARED: begin
          if (ang_r >= 11'd360) begin
            ang_r <= ang_r - 11'd360;
          end else begin
            // wheels 1 and 2 mounted reversed
            sn_r[wk_r] <= (wk_r < 2'd2) ? -sine_cur : sine_cur;
            if ((sine_cur[13] ? 13'(-sine_cur) : sine_cur[12:0]) > maxabs_r)
              maxabs_r <= sine_cur[13] ? 13'(-sine_cur) : sine_cur[12:0];
            wk_r    <= wk_r + 1'b1;
            state_r <= (wk_r == 2'(WC - 1)) ? S_ERR : S_ALOAD;
          end
        end
        S_ERR: begin
          err_r <= err_now[9:0];
          if (tick_r) begin
            err_chg_r  <= dsat;
            last_err_r <= err_now[9:0];
          end
          state_r <= S_PDM;
        end
        S_PDM: state_r <= S_PDA;
        S_PDA: begin
          acc_r   <= prod[25:0];
          state_r <= S_PDC;
        end
        S_PDC: begin
          pd_r    <= (pd_sum > 26'(clim_s)) ? clim_s :
                     (pd_sum < -26'(clim_s)) ? -clim_s : pd_sum[23:0];
          wk_r    <= '0;
          state_r <= S_WMUL;
        end
        S_WMUL: state_r <= S_WDIV;
        S_WDIV: begin
          zero_r  <= !div_start;
          state_r <= S_WWAIT;
        end
        S_WWAIT: if (zero_r || div_done) state_r <= S_WSUM;
        S_WSUM: begin
          p_r     <= p_clamp;
          state_r <= S_WSM1;
        end
        S_WSM1: state_r <= S_WSM2;
        S_WSM2: begin
          acc_r   <= prod[25:0];
          state_r <= S_WFIN;
        end
        S_WFIN: begin
          sm_r[wk_r] <= sm_rnd[15:0];
          if (brake_hit) begin
            duty_r[{wk_r, 1'b0}] <= 7'd100;
            duty_r[{wk_r, 1'b1}] <= 7'd100;
          end else begin
            duty_r[{wk_r, 1'b0}] <= (sm_rnd > 0) ? duty : 7'd0;
            duty_r[{wk_r, 1'b1}] <= sm_rnd[17] ? duty : 7'd0;
          end
          wk_r    <= wk_r + 1'b1;
          state_r <= (wk_r == 2'(WC - 1)) ? S_PUSH : S_WMUL;
        end
        S_PUSH: begin
          if (!out_valid_r || out_ch.ready) begin
            for (int k = 0; k < 2*WC; k++) out_duty_r[k] <= duty_r[k];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_start_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> state_r == S_WDIV) else $error("divide started out of sequence");
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == S_ALOAD) else $error("accept lost");
  a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && (!out_valid_r || out_ch.ready)) |=> out_valid_r)
    else $error("result not posted");
  a_spd_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WMUL) |-> spd_r <= plim_r) else $error("speed not clamped");
endmodule
